// ===== rtl/core/prle_pkg.sv =====
package prle_pkg;

    // Run counter width and its saturation value
    localparam int COUNT_BITS = 28;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Channel count modes
    localparam logic [1:0] MODE_L    = 2'd0;
    localparam logic [1:0] MODE_RGB  = 2'd1;
    localparam logic [1:0] MODE_RGBA = 2'd2;

    // Marker bytes
    localparam logic [7:0] CHAR_I = 8'h49;
    localparam logic [7:0] CHAR_M = 8'h4d;
    localparam logic [7:0] CHAR_S = 8'h53;
    localparam logic [7:0] CHAR_E = 8'h45;

    // Length of a run that opens and closes on the same pixel
    localparam logic [7:0] LEB_ONE = 8'h01;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       frame_end;
    } t_pixel_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_byte_item;

    // One pixel's worth of output work, in emission order
    typedef struct packed {
        logic                  has_start;
        logic                  has_blk_a;
        logic                  has_blk_b;
        logic                  has_end;
        logic [COUNT_BITS-1:0] len_a;
        logic [31:0]           pix_a;
        logic [31:0]           pix_b;
    } t_cmd;

    typedef enum logic [2:0] {
        PH_START,
        PH_LENA,
        PH_PIXA,
        PH_LENB,
        PH_PIXB,
        PH_END
    } t_phase;

endpackage

// ===== rtl/core/prle_front.sv =====
module prle_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  prle_pkg::t_pixel_item i_in_item,
    input  logic                  i_q_full,
    output logic                  o_q_push,
    output prle_pkg::t_cmd        o_q_cmd
);
    import prle_pkg::*;

    logic [31:0]           r_run_pixel, n_run_pixel;
    logic [COUNT_BITS-1:0] r_run_len, n_run_len;
    logic                  r_inside, n_inside;

    logic                  accept;
    logic [31:0]           px;
    logic                  differ;
    logic                  open_new;
    logic [COUNT_BITS-1:0] len_inc;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign px         = {i_in_item.alpha, i_in_item.blue, i_in_item.green, i_in_item.red};
    assign differ     = px != r_run_pixel;
    assign open_new   = !r_inside || differ;
    assign len_inc    = (r_run_len == COUNT_MAX) ? r_run_len : r_run_len + 1'b1;

    // Classify the pixel into a command and advance the run
    always_comb begin
        o_q_cmd.has_start = !r_inside;
        o_q_cmd.has_blk_a = r_inside && (differ || i_in_item.frame_end);
        o_q_cmd.has_blk_b = i_in_item.frame_end && open_new;
        o_q_cmd.has_end   = i_in_item.frame_end;
        o_q_cmd.len_a     = differ ? r_run_len : len_inc;
        o_q_cmd.pix_a     = r_run_pixel;
        o_q_cmd.pix_b     = px;
        o_q_push = accept && (o_q_cmd.has_start || o_q_cmd.has_blk_a || o_q_cmd.has_end);

        n_run_pixel = r_run_pixel;
        n_run_len   = r_run_len;
        n_inside    = r_inside;
        if (accept) begin
            if (open_new) begin
                n_run_pixel = px;
                n_run_len   = {{(COUNT_BITS-1){1'b0}}, 1'b1};
            end else begin
                n_run_len = len_inc;
            end
            n_inside = 1'b1;
            if (i_in_item.frame_end) begin
                n_inside  = 1'b0;
                n_run_len = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_pixel <= '0;
            r_run_len   <= '0;
            r_inside    <= 1'b0;
        end else begin
            r_run_pixel <= n_run_pixel;
            r_run_len   <= n_run_len;
            r_inside    <= n_inside;
        end
    end

endmodule

// ===== rtl/core/prle_queue.sv =====
module prle_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  prle_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_nonempty,
    output prle_pkg::t_cmd o_cmd
);
    import prle_pkg::*;

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QAW:0]   r_count;

    assign o_full     = r_count == QAW'(0) + (QAW+1)'(QDEPTH);
    assign o_nonempty = r_count != '0;
    assign o_cmd      = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/prle_back.sv =====
module prle_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [1:0]           i_pixel_mode,
    input  logic                 i_q_nonempty,
    input  prle_pkg::t_cmd       i_q_cmd,
    output logic                 o_q_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output prle_pkg::t_byte_item o_out_item
);
    import prle_pkg::*;

    t_cmd                  r_cmd, n_cmd;
    logic                  r_busy, n_busy;
    t_phase                r_phase, n_phase;
    logic [1:0]            r_idx, n_idx;
    logic [COUNT_BITS-1:0] r_lenv, n_lenv;
    logic                  r_out_valid, n_out_valid;
    t_byte_item            r_out_item, n_out_item;

    logic                  out_free;
    logic [7:0]            cur_byte;
    logic                  phase_done;
    logic                  has_next;
    t_phase                next_phase;
    t_phase                first_phase;
    logic [COUNT_BITS-1:0] rest;
    logic [1:0]            pix_last;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign rest        = r_lenv >> 7;

    // Index of the final channel byte per block
    always_comb begin
        case (i_pixel_mode)
            MODE_L:   pix_last = 2'd0;
            MODE_RGB: pix_last = 2'd2;
            default:  pix_last = 2'd3;
        endcase
    end

    // Current byte and whether it closes its phase
    always_comb begin
        cur_byte   = '0;
        phase_done = 1'b0;
        case (r_phase)
            PH_START, PH_END: begin
                case (r_idx)
                    2'd0:    cur_byte = CHAR_I;
                    2'd1:    cur_byte = CHAR_M;
                    default: cur_byte = (r_phase == PH_START) ? CHAR_S : CHAR_E;
                endcase
                phase_done = r_idx == 2'd2;
            end
            PH_LENA: begin
                cur_byte   = {rest != '0, r_lenv[6:0]};
                phase_done = rest == '0;
            end
            PH_LENB: begin
                cur_byte   = LEB_ONE;
                phase_done = 1'b1;
            end
            PH_PIXA: begin
                cur_byte   = r_cmd.pix_a[{r_idx, 3'b000} +: 8];
                phase_done = r_idx == pix_last;
            end
            PH_PIXB: begin
                cur_byte   = r_cmd.pix_b[{r_idx, 3'b000} +: 8];
                phase_done = r_idx == pix_last;
            end
            default: begin
                cur_byte   = '0;
                phase_done = 1'b1;
            end
        endcase
    end

    // Phase that follows the current one, if any
    always_comb begin
        has_next   = 1'b0;
        next_phase = PH_END;
        case (r_phase)
            PH_START: begin
                has_next = r_cmd.has_blk_a || r_cmd.has_blk_b || r_cmd.has_end;
                if (r_cmd.has_blk_a) begin
                    next_phase = PH_LENA;
                end else if (r_cmd.has_blk_b) begin
                    next_phase = PH_LENB;
                end
            end
            PH_LENA: begin
                has_next   = 1'b1;
                next_phase = PH_PIXA;
            end
            PH_PIXA: begin
                has_next = r_cmd.has_blk_b || r_cmd.has_end;
                if (r_cmd.has_blk_b) begin
                    next_phase = PH_LENB;
                end
            end
            PH_LENB: begin
                has_next   = 1'b1;
                next_phase = PH_PIXB;
            end
            PH_PIXB: begin
                has_next = r_cmd.has_end;
            end
            default: begin
                has_next = 1'b0;
            end
        endcase
    end

    // Entry phase of a freshly popped command
    always_comb begin
        if (i_q_cmd.has_start) begin
            first_phase = PH_START;
        end else if (i_q_cmd.has_blk_a) begin
            first_phase = PH_LENA;
        end else if (i_q_cmd.has_blk_b) begin
            first_phase = PH_LENB;
        end else begin
            first_phase = PH_END;
        end
    end

    // Sequencer and output register
    always_comb begin
        n_cmd       = r_cmd;
        n_busy      = r_busy;
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_lenv      = r_lenv;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        o_q_pop     = 1'b0;

        if (out_free) begin
            n_out_valid = r_busy;
            if (r_busy) begin
                n_out_item.out_byte  = cur_byte;
                n_out_item.last_byte = phase_done && !has_next;
                if (r_phase == PH_LENA) begin
                    n_lenv = rest;
                end
                if (phase_done) begin
                    n_idx = '0;
                    if (has_next) begin
                        n_phase = next_phase;
                    end else begin
                        n_busy = 1'b0;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
        end

        if (!r_busy && i_q_nonempty) begin
            o_q_pop = 1'b1;
            n_cmd   = i_q_cmd;
            n_busy  = 1'b1;
            n_phase = first_phase;
            n_idx   = '0;
            n_lenv  = i_q_cmd.len_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= PH_START;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_phase     <= n_phase;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_lenv     <= n_lenv;
        r_out_item <= n_out_item;
    end

endmodule

// ===== rtl/core/pixel_run_length_encoder.sv =====
// Channel   Direction  Handshake          Payload
// in        input      i_in_valid/o_in_stall    t_pixel_item (red,green,blue,alpha,frame_end)
// out       output     o_out_valid/i_out_stall  t_byte_item (out_byte,last_byte)
// cfg       input      i_cfg_valid/o_cfg_ready  i_cfg_data: pixel_mode
//
// One pixel is taken per cycle while the four-entry command queue has room.
// The byte side emits one byte per cycle from its output register while i_out_stall is
// low, and fetches a queued command only once the previous one has been emitted; a
// command carries 2 to 16 bytes. Pixels that only extend a run create no command.
// Reset is synchronous, active low; pixel_mode resets to RGBA.
module pixel_run_length_encoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  prle_pkg::t_pixel_item i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output prle_pkg::t_byte_item o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_data
);
    import prle_pkg::*;

    logic [1:0] r_pixel_mode;
    logic       q_full;
    logic       q_push;
    t_cmd       q_in_cmd;
    logic       q_pop;
    logic       q_nonempty;
    t_cmd       q_out_cmd;

    // Mode register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_mode <= MODE_RGBA;
        end else if (i_cfg_valid) begin
            r_pixel_mode <= i_cfg_data;
        end
    end

    prle_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_cmd    (q_in_cmd)
    );

    prle_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_cmd      (q_in_cmd),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_nonempty (q_nonempty),
        .o_cmd      (q_out_cmd)
    );

    prle_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pixel_mode (r_pixel_mode),
        .i_q_nonempty (q_nonempty),
        .i_q_cmd      (q_out_cmd),
        .o_q_pop      (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_item   (o_out_item)
    );

endmodule
